### sv/lbpg_pkg.sv
`default_nettype none

package lbpg_pkg;

   // width of the phase reload registers and down counters
   localparam int COUNT_WIDTH = 16;

   // four blink phases: on1, off1, on2, off2
   localparam int NUM_PHASES = 4;

   localparam int TIME_WIDTH = 16;
   localparam int OP_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 1;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [TIME_WIDTH-1:0] time_type;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_TICK   = 3'd0,
      OP_OFF    = 3'd1,
      OP_ON     = 3'd2,
      OP_PULSE  = 3'd3,
      OP_BLINK  = 3'd4,
      OP_BLINK2 = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      MODE_OFF    = 3'd0,
      MODE_ON     = 3'd1,
      MODE_PULSE  = 3'd2,
      MODE_BLINK  = 3'd3,
      MODE_BLINK2 = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ACTIVE_LOW = 2'd0,
      CSR_DISABLED   = 2'd1
   } csr_index_type;

   typedef struct packed {
      op_type   op;
      time_type time_on1;
      time_type time_off1;
      time_type time_on2;
      time_type time_off2;
      logic     phase_inverted;
   } item_type;

   typedef struct packed {
      logic active_low;
      logic disabled;
   } cfg_type;

   typedef struct packed {
      logic has_result;
      logic pin_level;
      logic pin_driven;
   } result_type;

endpackage

`default_nettype wire

### sv/lbpg_engine.sv
`default_nettype none

module lbpg_engine (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 fire,
   input  lbpg_pkg::item_type  item,
   input  lbpg_pkg::cfg_type   cfg,
   output lbpg_pkg::result_type result
);
   import lbpg_pkg::*;

   mode_type  mode_ff, mode_in;
   logic      phase_ff, phase_in;
   count_type reload_ff [NUM_PHASES];
   count_type reload_in [NUM_PHASES];
   count_type down_ff [NUM_PHASES];
   count_type down_in [NUM_PHASES];
   logic      level_ff, level_in;
   logic      driven_ff, driven_in;

   logic      do_tick;
   logic      phase_found;
   logic      lit;
   logic      blink2;

   assign blink2 = (mode_ff == MODE_BLINK2);
   assign do_tick = fire && (item.op == OP_TICK) && !cfg.disabled;

   always_comb begin
      mode_in     = mode_ff;
      phase_in    = phase_ff;
      reload_in   = reload_ff;
      down_in     = down_ff;
      level_in    = level_ff;
      driven_in   = driven_ff;
      phase_found = 1'b0;
      lit         = 1'b0;
      result.has_result = 1'b0;

      unique case (item.op)
         OP_TICK: begin
            if (!cfg.disabled) begin
               result.has_result = 1'b1;
               unique case (mode_ff) inside
                  MODE_OFF: begin
                     level_in  = cfg.active_low;
                     driven_in = 1'b1;
                  end
                  MODE_ON: begin
                     level_in  = ~cfg.active_low;
                     driven_in = 1'b1;
                  end
                  MODE_PULSE: begin
                     driven_in = 1'b1;
                     if (down_ff[0] != '0) begin
                        level_in   = ~cfg.active_low;
                        down_in[0] = down_ff[0] - count_type'(1);
                     end else begin
                        level_in = cfg.active_low;
                        mode_in  = MODE_OFF;
                     end
                  end
                  MODE_BLINK, MODE_BLINK2: begin
                     // first non-zero phase counter wins; plain blink has two phases
                     for (int i = 0; i < NUM_PHASES; i++) begin
                        if (!phase_found && (i < 2 || blink2) && down_ff[i] != '0) begin
                           phase_found = 1'b1;
                           lit         = ((i & 1) == 0);
                           down_in[i]  = down_ff[i] - count_type'(1);
                        end
                     end
                     if (phase_found) begin
                        level_in  = lit ^ phase_ff ^ cfg.active_low;
                        driven_in = 1'b1;
                     end else begin
                        // reload tick, pin left alone
                        for (int i = 0; i < NUM_PHASES; i++) begin
                           if (i < 2 || blink2) begin
                              down_in[i] = reload_ff[i];
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_OFF, OP_ON: begin
            mode_in = (item.op == OP_ON) ? MODE_ON : MODE_OFF;
            for (int i = 0; i < NUM_PHASES; i++) begin
               reload_in[i] = '0;
               down_in[i]   = '0;
            end
         end
         OP_PULSE: begin
            mode_in      = MODE_PULSE;
            reload_in[0] = count_type'(item.time_on1);
            reload_in[1] = '0;
            reload_in[2] = '0;
            reload_in[3] = '0;
            down_in      = reload_in;
         end
         OP_BLINK: begin
            mode_in      = MODE_BLINK;
            phase_in     = item.phase_inverted;
            reload_in[0] = count_type'(item.time_on1);
            reload_in[1] = count_type'(item.time_off1);
            reload_in[2] = '0;
            reload_in[3] = '0;
            down_in      = reload_in;
         end
         OP_BLINK2: begin
            mode_in      = MODE_BLINK2;
            phase_in     = item.phase_inverted;
            reload_in[0] = count_type'(item.time_on1);
            reload_in[1] = count_type'(item.time_off1);
            reload_in[2] = count_type'(item.time_on2);
            reload_in[3] = count_type'(item.time_off2);
            down_in      = reload_in;
         end
         default: begin
         end
      endcase

      result.pin_level  = level_in;
      result.pin_driven = driven_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OFF;
         phase_ff  <= 1'b0;
         level_ff  <= 1'b0;
         driven_ff <= 1'b0;
         for (int i = 0; i < NUM_PHASES; i++) begin
            reload_ff[i] <= '0;
            down_ff[i]   <= '0;
         end
      end else if (fire) begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         reload_ff <= reload_in;
         down_ff   <= down_in;
         level_ff  <= level_in;
         driven_ff <= driven_in;
      end
   end

   // once written, the pin stays an output
   a_driven_sticky: assert property (@(posedge clock) disable iff (reset)
      driven_ff |=> driven_ff)
      else $error("pin_driven dropped");

   // plain blink never touches the second on/off pair
   a_blink_pair_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_BLINK) |-> (down_ff[2] == '0 && down_ff[3] == '0))
      else $error("second blink pair active in plain blink");

   // pulse mode only ever loads the first reload register
   a_pulse_reloads: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_PULSE) |->
         (reload_ff[1] == '0 && reload_ff[2] == '0 && reload_ff[3] == '0))
      else $error("pulse mode with stray reload values");

   // steady on drives the lit level
   a_on_level: assert property (@(posedge clock) disable iff (reset)
      (do_tick && mode_ff == MODE_ON) |=> (driven_ff && level_ff == ~$past(cfg.active_low)))
      else $error("steady on drove the wrong level");

endmodule

`default_nettype wire

### sv/led_blink_pattern_generator_top.sv
`default_nettype none

// LED blink pattern generator: drives one indicator pin from a stream of
// command and tick transactions on the req_ channel. Commands (off, on, pulse,
// blink, double blink) load the phase counters and give no response; each tick
// advances the pattern and returns one rsp_ transaction with the pin level and
// whether the pin has been driven, unless csr register disabled is set. The
// block takes one transaction per cycle unless a held response stalls it.
// A request register feeds the counter update and the response register,
// which drives rsp_valid. The counter update is combinational, so
// back-to-back ticks run at full rate; a response held by rsp_stall stalls
// only transactions that produce a response. csr_ready is always high;
// configuration is meant to be written while the block is idle.

module led_blink_pattern_generator_top (
   input  wire                                      clock,
   input  wire                                      reset,
   // request channel
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire  [lbpg_pkg::OP_WIDTH-1:0]            req_operation,
   input  wire  [lbpg_pkg::TIME_WIDTH-1:0]          req_time_on1,
   input  wire  [lbpg_pkg::TIME_WIDTH-1:0]          req_time_off1,
   input  wire  [lbpg_pkg::TIME_WIDTH-1:0]          req_time_on2,
   input  wire  [lbpg_pkg::TIME_WIDTH-1:0]          req_time_off2,
   input  wire                                      req_phase_inverted,
   // response channel
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output logic                                     rsp_pin_level,
   output logic                                     rsp_pin_driven,
   // configuration write channel
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire  [lbpg_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire  [lbpg_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);
   import lbpg_pkg::*;

   // request register
   logic       item_valid_ff;
   item_type   item_ff;

   // response register
   logic       rsp_valid_ff;
   logic       rsp_pin_level_ff;
   logic       rsp_pin_driven_ff;

   // configuration
   cfg_type    cfg_ff;

   result_type result;
   logic       rsp_free;
   logic       fire;
   logic       req_accept;

   // response slot is free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // commands and disabled ticks need no response slot
   assign fire = item_valid_ff && (!result.has_result || rsp_free);

   assign req_stall  = item_valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_accept) begin
         item_valid_ff <= 1'b1;
      end else if (fire) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.op             <= op_type'(req_operation);
         item_ff.time_on1       <= req_time_on1;
         item_ff.time_off1      <= req_time_off1;
         item_ff.time_on2       <= req_time_on2;
         item_ff.time_off2      <= req_time_off2;
         item_ff.phase_inverted <= req_phase_inverted;
      end
   end

   // pattern state and per-transaction update
   lbpg_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // response register, loaded only by ticks that report
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && result.has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.has_result) begin
         rsp_pin_level_ff  <= result.pin_level;
         rsp_pin_driven_ff <= result.pin_driven;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_level  = rsp_pin_level_ff;
   assign rsp_pin_driven = rsp_pin_driven_ff;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_LOW: cfg_ff.active_low <= csr_wdata[0];
            CSR_DISABLED:   cfg_ff.disabled   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // a stalled response never blocks a transaction that has no response
   a_cmd_not_blocked: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !result.has_result) |-> fire)
      else $error("command held behind a stalled response");

   // a response waiting under stall is never overwritten
   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(fire && result.has_result))
      else $error("pending response overwritten");

   // the request register only holds when something stalls downstream
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("request stalled without a downstream stall");

endmodule

`default_nettype wire
